[rtl/single_line_writeback_byte_cache_unit_defines.svh]
// Assertion macros shared by the cache unit.
`ifndef SINGLE_LINE_WRITEBACK_BYTE_CACHE_UNIT_DEFINES_SVH
`define SINGLE_LINE_WRITEBACK_BYTE_CACHE_UNIT_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define SLWBC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define SLWBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/slwbc_pkg.sv]
package slwbc_pkg;

    // Geometry; LINE_BYTES must be a power of two
    localparam int LINE_BYTES      = 8;
    localparam int ADDR_BITS       = 16;
    localparam int ADDR_W          = 16;
    localparam int INVALIDATE_ADDR = 65535;
    localparam int IDX_BITS        = $clog2(LINE_BYTES);
    localparam int LINE_BITS       = ADDR_BITS - IDX_BITS;
    localparam int MEM_DEPTH       = 2 ** ADDR_BITS;

    typedef logic [ADDR_BITS-1:0] t_maddr;
    typedef logic [LINE_BITS-1:0] t_line;
    typedef logic [IDX_BITS-1:0]  t_idx;
    typedef logic [ADDR_W-1:0]    t_addr;
    typedef logic [7:0]           t_byte;

    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_ENABLE  = 2'd2,
        OP_DISABLE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_FLUSH,
        S_POST,
        S_FILL,
        S_BYTE_FILL,
        S_RESULT
    } t_state;

    // Action that follows a write-back pass
    typedef enum logic [1:0] {
        POST_FILL,
        POST_NEW_LINE,
        POST_DONE,
        POST_OFF
    } t_post;

    typedef enum logic [3:0] {
        DEC_OFF_RD,
        DEC_INV_RD,
        DEC_RD_MISS,
        DEC_RD_BYTE,
        DEC_RD_HIT,
        DEC_OFF_WR,
        DEC_INV_WR,
        DEC_WR_HIT,
        DEC_WR_NEW,
        DEC_ENABLE,
        DEC_DISABLE
    } t_dec;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_MEM,
        RES_LINE
    } t_res_sel;

    typedef enum logic [1:0] {
        MISS_NO,
        MISS_YES,
        MISS_WROTE
    } t_miss_sel;

    // Controller to datapath
    typedef struct packed {
        logic      load_in;
        logic      clr_mem;
        logic      flush_step;
        logic      fill_step;
        logic      byte_rd;
        logic      byte_fill;
        logic      off_rd;
        logic      off_wr;
        logic      clr_valid;
        logic      store_wr;
        logic      take_line;
        logic      set_on;
        logic      set_off;
        logic      res_load;
        t_res_sel  res_sel;
        t_miss_sel miss_sel;
        t_maddr    cnt;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_op  op;
        logic cache_on;
        logic is_inv;
        logic line_hit;
        logic any_valid;
        logic idx_valid;
        logic idx_dirty;
    } t_stat;

endpackage

[rtl/single_line_writeback_byte_cache_unit.sv]
// Hits, enable, cache-off accesses and writes to the held line pass S_DECODE and S_RESULT;
// a read miss first writes the held line back byte by byte (S_FLUSH), then refills the
// whole line from memory (S_FILL) before S_RESULT. One word is in work at a time;
// the single backing memory port and the byte-wide write-back/refill set the rate.
// Reset is synchronous, active low; afterwards a clearing pass zeroes the memory
// with o_stall held high.
`include "single_line_writeback_byte_cache_unit_defines.svh"

module single_line_writeback_byte_cache_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_read_data,
    output logic        o_missed
);

    slwbc_pkg::t_cmd  cmd;
    slwbc_pkg::t_stat stat;

    slwbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_out_stall (i_stall),
        .i_stat      (stat),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_cmd       (cmd)
    );

    slwbc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_operation  (i_operation),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_read_data  (o_read_data),
        .o_missed     (o_missed)
    );

    // At most one memory action per cycle
    `SLWBC_ASSERT_SAME(a_one_mem_op, i_clk, i_rst_n, 1'b1, $onehot0({cmd.clr_mem, cmd.flush_step, cmd.fill_step, cmd.byte_rd, cmd.off_rd, cmd.off_wr}), "two memory actions in one cycle")
    // A new result never overwrites a word still waiting downstream
    `SLWBC_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, cmd.res_load, !(o_valid && i_stall), "result loaded over a waiting word")
    // Busy after taking a word
    `SLWBC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "block free right after accepting a word")

endmodule

[rtl/slwbc_ctrl.sv]
module slwbc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_out_stall,
    input  slwbc_pkg::t_stat  i_stat,
    output logic              o_stall,
    output logic              o_valid,
    output slwbc_pkg::t_cmd   o_cmd
);

    slwbc_pkg::t_state    r_state, n_state;
    slwbc_pkg::t_maddr    r_cnt, n_cnt;
    slwbc_pkg::t_post     r_post, n_post;
    slwbc_pkg::t_res_sel  r_res_sel, n_res_sel;
    slwbc_pkg::t_miss_sel r_miss_sel, n_miss_sel;
    logic                 r_out_valid, n_out_valid;
    slwbc_pkg::t_dec      dec;
    logic                 slot_free;
    logic                 flush_last;
    logic                 fill_last;

    assign slot_free  = !r_out_valid || !i_out_stall;
    assign flush_last = (r_cnt == slwbc_pkg::t_maddr'(slwbc_pkg::LINE_BYTES - 1));
    assign fill_last  = (r_cnt == slwbc_pkg::t_maddr'(slwbc_pkg::LINE_BYTES));

    // Classify the held word against the cache state
    always_comb begin
        dec = slwbc_pkg::DEC_ENABLE;
        case (i_stat.op)
            slwbc_pkg::OP_READ: begin
                if (!i_stat.cache_on) begin
                    dec = slwbc_pkg::DEC_OFF_RD;
                end else if (i_stat.is_inv) begin
                    dec = slwbc_pkg::DEC_INV_RD;
                end else if (!i_stat.line_hit || !i_stat.any_valid) begin
                    dec = slwbc_pkg::DEC_RD_MISS;
                end else if (!i_stat.idx_valid && !i_stat.idx_dirty) begin
                    dec = slwbc_pkg::DEC_RD_BYTE;
                end else begin
                    dec = slwbc_pkg::DEC_RD_HIT;
                end
            end
            slwbc_pkg::OP_WRITE: begin
                if (!i_stat.cache_on) begin
                    dec = slwbc_pkg::DEC_OFF_WR;
                end else if (i_stat.is_inv) begin
                    dec = slwbc_pkg::DEC_INV_WR;
                end else if (i_stat.line_hit) begin
                    dec = slwbc_pkg::DEC_WR_HIT;
                end else begin
                    dec = slwbc_pkg::DEC_WR_NEW;
                end
            end
            slwbc_pkg::OP_ENABLE:  dec = slwbc_pkg::DEC_ENABLE;
            slwbc_pkg::OP_DISABLE: dec = slwbc_pkg::DEC_DISABLE;
            default:               dec = slwbc_pkg::DEC_ENABLE;
        endcase
    end

    // Next state
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_post     = r_post;
        n_res_sel  = r_res_sel;
        n_miss_sel = r_miss_sel;
        case (r_state)
            slwbc_pkg::S_CLEAR: begin
                n_cnt = r_cnt + 1'b1;
                if (&r_cnt) begin
                    n_state = slwbc_pkg::S_IDLE;
                end
            end
            slwbc_pkg::S_IDLE: begin
                n_cnt = '0;
                if (i_valid) begin
                    n_state = slwbc_pkg::S_DECODE;
                end
            end
            slwbc_pkg::S_DECODE: begin
                n_cnt = '0;
                case (dec)
                    slwbc_pkg::DEC_OFF_RD: begin
                        n_state    = slwbc_pkg::S_RESULT;
                        n_res_sel  = slwbc_pkg::RES_MEM;
                        n_miss_sel = slwbc_pkg::MISS_YES;
                    end
                    slwbc_pkg::DEC_RD_MISS: begin
                        n_state    = slwbc_pkg::S_FLUSH;
                        n_post     = slwbc_pkg::POST_FILL;
                        n_res_sel  = slwbc_pkg::RES_LINE;
                        n_miss_sel = slwbc_pkg::MISS_YES;
                    end
                    slwbc_pkg::DEC_RD_BYTE: begin
                        n_state    = slwbc_pkg::S_BYTE_FILL;
                        n_res_sel  = slwbc_pkg::RES_LINE;
                        n_miss_sel = slwbc_pkg::MISS_YES;
                    end
                    slwbc_pkg::DEC_RD_HIT: begin
                        n_state    = slwbc_pkg::S_RESULT;
                        n_res_sel  = slwbc_pkg::RES_LINE;
                        n_miss_sel = slwbc_pkg::MISS_NO;
                    end
                    slwbc_pkg::DEC_OFF_WR: begin
                        n_state    = slwbc_pkg::S_RESULT;
                        n_res_sel  = slwbc_pkg::RES_ZERO;
                        n_miss_sel = slwbc_pkg::MISS_YES;
                    end
                    slwbc_pkg::DEC_INV_WR: begin
                        n_state    = slwbc_pkg::S_FLUSH;
                        n_post     = slwbc_pkg::POST_DONE;
                        n_res_sel  = slwbc_pkg::RES_ZERO;
                        n_miss_sel = slwbc_pkg::MISS_WROTE;
                    end
                    slwbc_pkg::DEC_WR_NEW: begin
                        n_state    = slwbc_pkg::S_FLUSH;
                        n_post     = slwbc_pkg::POST_NEW_LINE;
                        n_res_sel  = slwbc_pkg::RES_ZERO;
                        n_miss_sel = slwbc_pkg::MISS_WROTE;
                    end
                    slwbc_pkg::DEC_DISABLE: begin
                        n_state    = slwbc_pkg::S_FLUSH;
                        n_post     = slwbc_pkg::POST_OFF;
                        n_res_sel  = slwbc_pkg::RES_ZERO;
                        n_miss_sel = slwbc_pkg::MISS_NO;
                    end
                    default: begin
                        // invalidate read, write hit and enable finish here
                        n_state    = slwbc_pkg::S_RESULT;
                        n_res_sel  = slwbc_pkg::RES_ZERO;
                        n_miss_sel = slwbc_pkg::MISS_NO;
                    end
                endcase
            end
            slwbc_pkg::S_FLUSH: begin
                n_cnt = r_cnt + 1'b1;
                if (flush_last) begin
                    n_cnt = '0;
                    if (r_post == slwbc_pkg::POST_FILL) begin
                        n_state = slwbc_pkg::S_FILL;
                    end else begin
                        n_state = slwbc_pkg::S_POST;
                    end
                end
            end
            slwbc_pkg::S_POST: begin
                n_state = slwbc_pkg::S_RESULT;
            end
            slwbc_pkg::S_FILL: begin
                n_cnt = r_cnt + 1'b1;
                if (fill_last) begin
                    n_cnt   = '0;
                    n_state = slwbc_pkg::S_RESULT;
                end
            end
            slwbc_pkg::S_BYTE_FILL: begin
                n_state = slwbc_pkg::S_RESULT;
            end
            slwbc_pkg::S_RESULT: begin
                if (slot_free) begin
                    n_state = slwbc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = slwbc_pkg::S_IDLE;
            end
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd          = '0;
        o_cmd.res_sel  = r_res_sel;
        o_cmd.miss_sel = r_miss_sel;
        o_cmd.cnt      = r_cnt;
        case (r_state)
            slwbc_pkg::S_CLEAR: o_cmd.clr_mem = 1'b1;
            slwbc_pkg::S_IDLE:  o_cmd.load_in = i_valid;
            slwbc_pkg::S_DECODE: begin
                case (dec)
                    slwbc_pkg::DEC_OFF_RD: o_cmd.off_rd    = 1'b1;
                    slwbc_pkg::DEC_INV_RD: o_cmd.clr_valid = 1'b1;
                    slwbc_pkg::DEC_RD_BYTE: o_cmd.byte_rd  = 1'b1;
                    slwbc_pkg::DEC_OFF_WR: o_cmd.off_wr    = 1'b1;
                    slwbc_pkg::DEC_WR_HIT: o_cmd.store_wr  = 1'b1;
                    slwbc_pkg::DEC_ENABLE: o_cmd.set_on    = 1'b1;
                    default: ;
                endcase
            end
            slwbc_pkg::S_FLUSH: o_cmd.flush_step = 1'b1;
            slwbc_pkg::S_POST: begin
                case (r_post)
                    slwbc_pkg::POST_NEW_LINE: begin
                        o_cmd.take_line = 1'b1;
                        o_cmd.clr_valid = 1'b1;
                        o_cmd.store_wr  = 1'b1;
                    end
                    slwbc_pkg::POST_OFF: o_cmd.set_off = 1'b1;
                    default: ;
                endcase
            end
            slwbc_pkg::S_FILL: begin
                o_cmd.fill_step = 1'b1;
                o_cmd.take_line = fill_last;
            end
            slwbc_pkg::S_BYTE_FILL: o_cmd.byte_fill = 1'b1;
            slwbc_pkg::S_RESULT:    o_cmd.res_load  = slot_free;
            default: ;
        endcase
    end

    // Output word flag: set on load, drop when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.res_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= slwbc_pkg::S_CLEAR;
            r_cnt       <= '0;
            r_post      <= slwbc_pkg::POST_DONE;
            r_res_sel   <= slwbc_pkg::RES_ZERO;
            r_miss_sel  <= slwbc_pkg::MISS_NO;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_post      <= n_post;
            r_res_sel   <= n_res_sel;
            r_miss_sel  <= n_miss_sel;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != slwbc_pkg::S_IDLE);
    assign o_valid = r_out_valid;

endmodule

[rtl/slwbc_dp.sv]
module slwbc_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_operation,
    input  logic [15:0]       i_address,
    input  logic [7:0]        i_write_data,
    input  slwbc_pkg::t_cmd   i_cmd,
    output slwbc_pkg::t_stat  o_stat,
    output logic [7:0]        o_read_data,
    output logic              o_missed
);

    // Held word
    slwbc_pkg::t_op    r_op;
    slwbc_pkg::t_addr  r_addr;
    slwbc_pkg::t_byte  r_wdata;

    // Line state
    slwbc_pkg::t_byte                    r_line [slwbc_pkg::LINE_BYTES];
    logic [slwbc_pkg::LINE_BYTES-1:0]    r_valid, n_valid;
    logic [slwbc_pkg::LINE_BYTES-1:0]    r_dirty, n_dirty;
    slwbc_pkg::t_line                    r_held;
    logic                                r_held_flag;
    logic                                r_on;
    logic                                r_wrote;

    // Backing memory
    slwbc_pkg::t_byte  mem [slwbc_pkg::MEM_DEPTH];
    slwbc_pkg::t_byte  r_mem_rdata;

    // Result register
    slwbc_pkg::t_byte  r_read_data;
    logic              r_missed;

    slwbc_pkg::t_maddr a_mem;
    slwbc_pkg::t_line  a_line;
    slwbc_pkg::t_idx   a_idx;
    slwbc_pkg::t_idx   c_idx;
    slwbc_pkg::t_idx   f_idx;
    logic              fill_issue;
    logic              fill_take;
    logic              flush_wr;

    logic              mem_re;
    slwbc_pkg::t_maddr mem_raddr;
    logic              mem_we;
    slwbc_pkg::t_maddr mem_waddr;
    slwbc_pkg::t_byte  mem_wdata;

    logic              ls_we;
    slwbc_pkg::t_idx   ls_widx;
    slwbc_pkg::t_byte  ls_wdata;
    slwbc_pkg::t_idx   ls_ridx;
    slwbc_pkg::t_byte  ls_rdata;

    // Split the address into line and byte
    assign a_mem  = slwbc_pkg::t_maddr'(r_addr);
    assign a_line = a_mem[slwbc_pkg::ADDR_BITS-1:slwbc_pkg::IDX_BITS];
    assign a_idx  = a_mem[slwbc_pkg::IDX_BITS-1:0];
    assign c_idx  = i_cmd.cnt[slwbc_pkg::IDX_BITS-1:0];
    assign f_idx  = c_idx - 1'b1;

    assign fill_issue = i_cmd.fill_step
                        && (i_cmd.cnt < slwbc_pkg::t_maddr'(slwbc_pkg::LINE_BYTES));
    assign fill_take  = i_cmd.fill_step && (i_cmd.cnt != '0);
    assign flush_wr   = i_cmd.flush_step && r_dirty[c_idx];

    // Status
    assign o_stat.op        = r_op;
    assign o_stat.cache_on  = r_on;
    assign o_stat.is_inv    = (r_addr == slwbc_pkg::t_addr'(slwbc_pkg::INVALIDATE_ADDR));
    assign o_stat.line_hit  = r_held_flag && (a_line == r_held);
    assign o_stat.any_valid = |r_valid;
    assign o_stat.idx_valid = r_valid[a_idx];
    assign o_stat.idx_dirty = r_dirty[a_idx];

    // Memory port selection
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = a_mem;
        if (i_cmd.off_rd || i_cmd.byte_rd) begin
            mem_re = 1'b1;
        end else if (fill_issue) begin
            mem_re    = 1'b1;
            mem_raddr = {a_line, c_idx};
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = a_mem;
        mem_wdata = r_wdata;
        if (i_cmd.clr_mem) begin
            mem_we    = 1'b1;
            mem_waddr = i_cmd.cnt;
            mem_wdata = '0;
        end else if (flush_wr) begin
            mem_we    = 1'b1;
            mem_waddr = {r_held, c_idx};
            mem_wdata = ls_rdata;
        end else if (i_cmd.off_wr) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_rdata <= mem[mem_raddr];
        end
    end

    // Line store port selection
    assign ls_ridx  = i_cmd.flush_step ? c_idx : a_idx;
    assign ls_rdata = r_line[ls_ridx];

    always_comb begin
        ls_we    = 1'b0;
        ls_widx  = a_idx;
        ls_wdata = r_mem_rdata;
        if (i_cmd.store_wr) begin
            ls_we    = 1'b1;
            ls_wdata = r_wdata;
        end else if (i_cmd.byte_fill) begin
            ls_we = 1'b1;
        end else if (fill_take) begin
            ls_we   = 1'b1;
            ls_widx = f_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ls_we) begin
            r_line[ls_widx] <= ls_wdata;
        end
    end

    // Valid and written marks
    always_comb begin
        n_valid = r_valid;
        n_dirty = r_dirty;
        if (i_cmd.clr_valid) begin
            n_valid = '0;
        end
        if (i_cmd.store_wr) begin
            n_valid[a_idx] = 1'b0;
            n_dirty[a_idx] = 1'b1;
        end
        if (flush_wr) begin
            n_valid[c_idx] = 1'b1;
            n_dirty[c_idx] = 1'b0;
        end
        if (i_cmd.byte_fill) begin
            n_valid[a_idx] = 1'b1;
        end
        if (fill_take) begin
            n_valid[f_idx] = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_dirty     <= '0;
            r_held      <= '0;
            r_held_flag <= 1'b0;
            r_on        <= 1'b0;
            r_wrote     <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_dirty <= n_dirty;
            if (i_cmd.take_line) begin
                r_held      <= a_line;
                r_held_flag <= 1'b1;
            end
            if (i_cmd.set_on) begin
                r_on <= 1'b1;
            end else if (i_cmd.set_off) begin
                r_on <= 1'b0;
            end
            if (i_cmd.load_in) begin
                r_wrote <= 1'b0;
            end else if (flush_wr) begin
                r_wrote <= 1'b1;
            end
        end
    end

    // Capture the incoming word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op    <= slwbc_pkg::t_op'(i_operation);
            r_addr  <= i_address;
            r_wdata <= i_write_data;
        end
    end

    // Load the result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            case (i_cmd.res_sel)
                slwbc_pkg::RES_MEM:  r_read_data <= r_mem_rdata;
                slwbc_pkg::RES_LINE: r_read_data <= ls_rdata;
                default:             r_read_data <= '0;
            endcase
            case (i_cmd.miss_sel)
                slwbc_pkg::MISS_YES:   r_missed <= 1'b1;
                slwbc_pkg::MISS_WROTE: r_missed <= r_wrote;
                default:               r_missed <= 1'b0;
            endcase
        end
    end

    assign o_read_data = r_read_data;
    assign o_missed    = r_missed;

endmodule

[verif/tb_single_line_writeback_byte_cache_unit.sv]
module tb_single_line_writeback_byte_cache_unit;
    import slwbc_pkg::*;

    localparam int N_RANDOM       = 1425;
    localparam int SETTLE_CYCLES  = 40;
    localparam int TIMEOUT_CYCLES = 1_000_000;

    typedef struct {
        bit [7:0] read_data;
        bit       missed;
    } access_result_t;

    // Shadow copy of the cache and its memory, plus the queue of predicted results
    class cache_result_board;
        bit [7:0]            mem_bytes [MEM_DEPTH];
        bit [7:0]            line_data [LINE_BYTES];
        bit [LINE_BYTES-1:0] valid_marks;
        bit [LINE_BYTES-1:0] dirty_marks;
        t_line               held_line;
        bit                  line_held;
        bit                  cache_on;
        access_result_t      pending_results [$];
        int                  errors;

        function new();
            valid_marks = '0;
            dirty_marks = '0;
            held_line   = '0;
            line_held   = 1'b0;
            cache_on    = 1'b0;
            errors      = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Copy dirty bytes back to memory; they become clean and valid
        function bit write_back_line();
            bit wrote;
            wrote = 1'b0;
            for (int i = 0; i < LINE_BYTES; i++) begin
                if (dirty_marks[i]) begin
                    mem_bytes[{held_line, t_idx'(i)}] = line_data[i];
                    dirty_marks[i] = 1'b0;
                    valid_marks[i] = 1'b1;
                    wrote = 1'b1;
                end
            end
            return wrote;
        endfunction

        function void store_byte(t_idx idx, t_byte data);
            line_data[idx]   = data;
            dirty_marks[idx] = 1'b1;
            valid_marks[idx] = 1'b0;
        endfunction

        function access_result_t predict_access(t_op op, t_addr addr, t_byte data);
            access_result_t res;
            t_line          line;
            t_idx           idx;
            bit             is_inv;
            res    = '{read_data: 8'h00, missed: 1'b0};
            line   = addr[ADDR_BITS-1:IDX_BITS];
            idx    = addr[IDX_BITS-1:0];
            is_inv = (addr == t_addr'(INVALIDATE_ADDR));
            case (op)
                OP_READ: begin
                    if (!cache_on) begin
                        res.missed    = 1'b1;
                        res.read_data = mem_bytes[t_maddr'(addr)];
                    end else if (is_inv) begin
                        valid_marks = '0;
                    end else begin
                        if (!line_held || line != held_line || valid_marks == '0) begin
                            void'(write_back_line());
                            for (int i = 0; i < LINE_BYTES; i++)
                                line_data[i] = mem_bytes[{line, t_idx'(i)}];
                            valid_marks = '1;
                            held_line   = line;
                            line_held   = 1'b1;
                            res.missed  = 1'b1;
                        end else if (!valid_marks[idx] && !dirty_marks[idx]) begin
                            // clean invalid byte: refill just this one
                            line_data[idx]   = mem_bytes[t_maddr'(addr)];
                            valid_marks[idx] = 1'b1;
                            res.missed       = 1'b1;
                        end
                        res.read_data = line_data[idx];
                    end
                end
                OP_WRITE: begin
                    if (!cache_on) begin
                        mem_bytes[t_maddr'(addr)] = data;
                        res.missed = 1'b1;
                    end else if (is_inv) begin
                        res.missed = write_back_line();
                    end else if (line_held && line == held_line) begin
                        store_byte(idx, data);
                    end else begin
                        res.missed  = write_back_line();
                        held_line   = line;
                        line_held   = 1'b1;
                        valid_marks = '0;
                        store_byte(idx, data);
                    end
                end
                OP_ENABLE: cache_on = 1'b1;
                default: begin
                    void'(write_back_line());
                    cache_on = 1'b0;
                end
            endcase
            return res;
        endfunction

        function void note_word(t_op op, t_addr addr, t_byte data);
            pending_results.push_back(predict_access(op, addr, data));
        endfunction

        function void check_word(logic [7:0] read_data, logic missed);
            access_result_t want;
            if (pending_results.size() == 0) begin
                $error("result word with nothing predicted: read_data 0x%02h missed %0b",
                       read_data, missed);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (read_data !== want.read_data) begin
                $error("read_data: expected 0x%02h, got 0x%02h", want.read_data, read_data);
                errors++;
            end
            if (missed !== want.missed) begin
                $error("missed: expected %0b, got %0b", want.missed, missed);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_operation;
    logic [15:0] i_address;
    logic [7:0]  i_write_data;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_read_data;
    logic        o_missed;

    cache_result_board board;
    t_line             line_pool [4];
    bit                send_calm;

    single_line_writeback_byte_cache_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_read_data  (o_read_data),
        .o_missed     (o_missed)
    );

    always #2 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Favour a few lines so that hits and partial refills happen often
    function automatic t_addr pick_address();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return {line_pool[$urandom_range(0, 3)], t_idx'($urandom_range(0, LINE_BYTES - 1))};
        if (r < 80)
            return t_addr'(INVALIDATE_ADDR);
        return t_addr'($urandom_range(0, MEM_DEPTH - 1));
    endfunction

    // Hold the word until the block takes it, then note it
    task automatic send_word(input t_op op, input t_addr addr, input t_byte data);
        i_valid      <= 1'b1;
        i_operation  <= op;
        i_address    <= addr;
        i_write_data <= data;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        board.note_word(op, addr, data);
    endtask

    task automatic idle_sender(input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait for every predicted result to come back
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    // Receive side: check accepted words, stall in random runs
    initial begin
        int  stall_left;
        int  open_left;
        int  calm_left;
        bit  calm;
        stall_left = 0;
        open_left  = 0;
        calm_left  = 0;
        calm       = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0)
                board.check_word(o_read_data, o_missed);
            if (stall_left == 0 && open_left == 0) begin
                if (calm_left == 0) begin
                    calm      = ($urandom_range(0, 3) == 0);
                    calm_left = $urandom_range(20, 80);
                end
                calm_left--;
                stall_left = pick_gap(calm);
                open_left  = $urandom_range(1, 6);
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
                open_left--;
            end
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * 4);
        $display("** single_line_writeback_byte_cache_unit: FAILED **");
        $finish;
    end

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_stall      = 1'b0;
        i_operation  = OP_READ;
        i_address    = '0;
        i_write_data = '0;
        send_calm    = 1'b0;
        board        = new();
        line_pool[0] = '0;
        line_pool[1] = '1;
        line_pool[2] = t_line'(16'h1230 >> IDX_BITS);
        line_pool[3] = t_line'(16'h4000 >> IDX_BITS);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: cache off, flush with no line held, invalidate, misses and hits
        send_word(OP_READ,    16'h0000, 8'h00);
        send_word(OP_WRITE,   16'h1234, 8'hA5);
        send_word(OP_READ,    16'h1234, 8'h00);
        send_word(OP_READ,    16'hFFFF, 8'h00);
        send_word(OP_ENABLE,  16'h0000, 8'h00);
        send_word(OP_WRITE,   16'hFFFF, 8'h00);
        send_word(OP_READ,    16'hFFFF, 8'h00);
        send_word(OP_WRITE,   16'h0003, 8'hFF);
        send_word(OP_READ,    16'h0003, 8'h00);
        send_word(OP_READ,    16'h0001, 8'h00);
        send_word(OP_WRITE,   16'h0005, 8'h5A);
        send_word(OP_READ,    16'h0005, 8'h00);
        send_word(OP_READ,    16'hFFFF, 8'h00);
        send_word(OP_READ,    16'h0006, 8'h00);
        send_word(OP_WRITE,   16'h1230, 8'hC3);
        send_word(OP_WRITE,   16'hFFFF, 8'h00);
        send_word(OP_WRITE,   16'hFFFF, 8'h00);
        send_word(OP_READ,    16'h1233, 8'h00);
        send_word(OP_READ,    16'h1230, 8'h00);
        send_word(OP_WRITE,   16'h4000, 8'h11);
        send_word(OP_WRITE,   16'hFFFE, 8'hFF);
        send_word(OP_WRITE,   16'hFFF8, 8'h00);
        send_word(OP_DISABLE, 16'h0000, 8'h00);
        send_word(OP_READ,    16'hFFFE, 8'h00);
        send_word(OP_ENABLE,  16'h0000, 8'h00);
        send_word(OP_READ,    16'hFFF8, 8'h00);
        drain_results();

        // Random: mostly reads and writes on a small set of lines
        for (int n = 0; n < N_RANDOM; n++) begin
            t_op   op;
            int    r;
            if (n % 200 == 0) begin
                line_pool[2] = t_line'($urandom_range(0, (1 << LINE_BITS) - 1));
                line_pool[3] = t_line'($urandom_range(0, (1 << LINE_BITS) - 1));
                send_calm    = ($urandom_range(0, 2) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 45)
                op = OP_READ;
            else if (r < 86)
                op = OP_WRITE;
            else if (r < 94)
                op = OP_ENABLE;
            else
                op = OP_DISABLE;
            send_word(op, pick_address(), t_byte'($urandom_range(0, 255)));
            if (n % 300 == 299)
                drain_results();
            else
                idle_sender(pick_gap(send_calm));
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.pending() != 0)
            $error("%0d predicted results never arrived", board.pending());
        if (board.errors == 0 && board.pending() == 0)
            $display("** single_line_writeback_byte_cache_unit: PASSED **");
        else
            $display("** single_line_writeback_byte_cache_unit: FAILED **");
        $finish;
    end

endmodule
